// File: rtl/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// Shared codes and widths for the periodic alarm scheduler.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int CNT_W = 32;
  localparam int PER_W = 16;
  localparam int OUT_SLOT_W = 3;

  typedef logic [1:0] op_t;

  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_OPEN  = 2'd1;
  localparam op_t OP_CLOSE = 2'd2;

  // one table entry: handler flag above the period
  typedef struct packed {
    logic             hand;
    logic [PER_W-1:0] per;
  } entry_t;

endpackage

// File: rtl/periodic_alarm_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_alarm_scheduler
// Alarm slot table in a synchronous memory, walked on each tick
// with a shared bit-serial modulo unit.
// ----------------------------------------------------------------------------
// Open, close and unused ops: accepted, no result.
// Tick: each slot is read and checked; an armed slot also runs 32
//   remainder steps and fires when the remainder is zero, then the held
//   hit is flushed; a stalled output holds the walk.
//   The bit-serial modulo unit and single memory read port set its length.
// Reset clears the count, the per-slot valid bits and all control; table
// contents are undefined until written and read as zero until then.
module periodic_alarm_scheduler
  import pas_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [2:0]            slot,
  input  logic [PER_W-1:0]      period,
  input  logic                  has_handler,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_SLOT_W-1:0] fired_slot,
  output logic                  last_of_tick
);

  // index width into the table, and a walk counter that can reach SLOTS
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW = $clog2(SLOTS + 1);
  localparam int DCW = $clog2(CNT_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_HIT   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] tick_count;
  logic [KW-1:0]    k;
  logic [SW-1:0]    k_idx;

  // table storage; valid bits stand in for the all-zero reset
  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] vld;
  entry_t           rd_data;
  logic             rd_vld;
  entry_t           ent;

  // modulo unit
  logic [CNT_W-1:0] div_num;
  logic [PER_W-1:0] div_per;
  logic [PER_W-1:0] rem;
  logic [DCW-1:0]   div_cnt;
  logic [PER_W:0]   rem_sh;
  logic [PER_W:0]   rem_sub;
  logic [PER_W-1:0] rem_next;

  // one held hit, so the last one of a tick can be marked
  logic [OUT_SLOT_W-1:0] pend_slot;
  logic                  pend_valid;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          wr_en;
  logic [SW-1:0] slot_idx;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // output register takes the held hit this cycle
  assign out_load = pend_valid && out_free && (state == S_HIT || state == S_FLUSH);
  assign k_idx    = k[SW-1:0];
  assign slot_idx = SW'({{SW{1'b0}}, slot});
  assign wr_en    = in_acc && (op == OP_OPEN || op == OP_CLOSE)
                    && ({3'b000, slot} < 6'(SLOTS));

  assign ent = rd_vld ? rd_data : '0;

  always_comb begin
    rem_sh  = {rem, div_num[CNT_W-1]};
    rem_sub = rem_sh - {1'b0, div_per};
    if (rem_sh >= {1'b0, div_per}) begin
      rem_next = rem_sub[PER_W-1:0];
    end else begin
      rem_next = rem_sh[PER_W-1:0];
    end
  end

  // memory: one write port for open/close, one registered read for the walk
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (op == OP_OPEN) begin
        mem[slot_idx] <= '{hand: has_handler, per: period};
      end else begin
        mem[slot_idx] <= '0;
      end
    end
    rd_data <= mem[k_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[slot_idx] <= 1'b1;
      end
      rd_vld <= vld[k_idx];
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      k          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && op == OP_TICK) begin
            tick_count <= tick_count + 1'b1;
            k          <= '0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          // read of slot k issues at this edge
          if (k == KW'(SLOTS)) begin
            state <= S_FLUSH;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ent.per != '0 && ent.hand) begin
            div_num <= tick_count;
            div_per <= ent.per;
            rem     <= '0;
            div_cnt <= DCW'(CNT_W - 1);
            state   <= S_DIV;
          end else begin
            k     <= k + 1'b1;
            state <= S_RD;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          div_num <= div_num << 1;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            if (rem_next == '0) begin
              state <= S_HIT;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_HIT: begin
          // previous hit is not the last one; push it out, hold this one
          if (out_free) begin
            if (pend_valid) begin
              out_valid    <= 1'b1;
              fired_slot   <= pend_slot;
              last_of_tick <= 1'b0;
            end
            pend_slot  <= OUT_SLOT_W'({3'b000, k});
            pend_valid <= 1'b1;
            k          <= k + 1'b1;
            state      <= S_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            fired_slot   <= pend_slot;
            last_of_tick <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a tick advances the count by exactly one
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    in_acc && op == OP_TICK |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick count did not advance by one");

  // open, close and unused ops leave the count alone
  a_cfg_keep: assert property (@(posedge clk) disable iff (rst)
    in_acc && op != OP_TICK |=> $stable(tick_count))
    else $error("non-tick transaction changed tick count");

  // remainder stays below the divisor throughout the modulo
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < div_per)
    else $error("modulo remainder out of range");

  // no held hit survives a finished walk
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held hit left over after tick");

endmodule
